// ===== design/m2q_pkg.sv =====
// shared types, constants and formats for the matrix to quaternion converter
package m2q_pkg;

   // fixed point formats
   localparam int Q_BITS        = 30;
   localparam int OUT_FRAC_BITS = 30;
   localparam int OUT_SHIFT     = Q_BITS - OUT_FRAC_BITS;
   localparam int ROUND_HALF    = (1 << OUT_SHIFT) >> 1;

   // pipeline depths of the shared units
   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 31;

   // one in Q.30, wide enough for the trace sums
   localparam logic signed [33:0] ONE_Q = 34'sd1 << Q_BITS;

   // diagonal pick
   localparam logic [1:0] IDX_0 = 2'd0;
   localparam logic [1:0] IDX_1 = 2'd1;
   localparam logic [1:0] IDX_2 = 2'd2;

   // component that comes from half the root, order w x y z
   localparam logic [3:0] HALF_W = 4'b0001;
   localparam logic [3:0] HALF_X = 4'b0010;
   localparam logic [3:0] HALF_Y = 4'b0100;
   localparam logic [3:0] HALF_Z = 4'b1000;

   typedef struct packed {
      logic signed [31:0] r0c0;
      logic signed [31:0] r0c1;
      logic signed [31:0] r0c2;
      logic signed [31:0] r1c0;
      logic signed [31:0] r1c1;
      logic signed [31:0] r1c2;
      logic signed [31:0] r2c0;
      logic signed [31:0] r2c1;
      logic signed [31:0] r2c2;
   } req_type;

   typedef struct packed {
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
      logic               degenerate;
   } rsp_type;

   // merge stage result, carried through the second root
   typedef struct packed {
      logic             degen;
      logic [3:0]       half_sel;
      logic [3:0]       num_neg;
      logic [3:0][31:0] num_mag;
      logic [63:0]      arg;
   } sel_type;

   // sideband carried through the final divide
   typedef struct packed {
      logic        degen;
      logic [3:0]  half_sel;
      logic [30:0] half_val;
   } fin_type;

endpackage

// ===== design/m2q_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module m2q_sqrt import m2q_pkg::*; (
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] radicand,
   output logic [31:0] root
);

   logic [63:0] rad_ff  [SQRT_STAGES];
   logic [63:0] rad_in  [SQRT_STAGES];
   logic [33:0] rem_ff  [SQRT_STAGES];
   logic [33:0] rem_in  [SQRT_STAGES];
   logic [31:0] root_ff [SQRT_STAGES];
   logic [31:0] root_in [SQRT_STAGES];
   logic [63:0] src_rad [SQRT_STAGES];
   logic [33:0] src_rem [SQRT_STAGES];
   logic [31:0] src_root[SQRT_STAGES];
   logic [35:0] cur     [SQRT_STAGES];
   logic [35:0] trial   [SQRT_STAGES];

   // stage inputs
   always_comb begin
      src_rad[0]  = radicand;
      src_rem[0]  = '0;
      src_root[0] = '0;
      for (int s = 1; s < SQRT_STAGES; s++) begin
         src_rad[s]  = rad_ff[s-1];
         src_rem[s]  = rem_ff[s-1];
         src_root[s] = root_ff[s-1];
      end
   end

   // one restoring step per stage on the next two radicand bits
   always_comb begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
         cur[s]   = {src_rem[s], src_rad[s][63:62]};
         trial[s] = {2'b00, src_root[s], 2'b01};
         rad_in[s] = {src_rad[s][61:0], 2'b00};
         if (cur[s] >= trial[s]) begin
            rem_in[s]  = 34'(cur[s] - trial[s]);
            root_in[s] = {src_root[s][30:0], 1'b1};
         end else begin
            rem_in[s]  = cur[s][33:0];
            root_in[s] = {src_root[s][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

// ===== design/m2q_div.sv =====
// pipelined signed Q.30 divide, num * 2^30 / den, one quotient bit per stage
module m2q_div import m2q_pkg::*; (
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] num_mag,
   input  logic        num_neg,
   input  logic [32:0] den,
   output logic [31:0] quot
);

   logic [32:0] rem_ff  [DIV_STAGES];
   logic [32:0] rem_in  [DIV_STAGES];
   logic [30:0] q_ff    [DIV_STAGES];
   logic [30:0] q_in    [DIV_STAGES];
   logic [32:0] den_ff  [DIV_STAGES];
   logic [32:0] den_in  [DIV_STAGES];
   logic        neg_ff  [DIV_STAGES];
   logic        neg_in  [DIV_STAGES];
   logic [33:0] cur     [DIV_STAGES];
   logic [30:0] src_q   [DIV_STAGES];

   // stage inputs: the first stage sees the whole numerator, later ones shift in zeros
   always_comb begin
      cur[0]    = {2'b00, num_mag};
      src_q[0]  = '0;
      den_in[0] = den;
      neg_in[0] = num_neg;
      for (int s = 1; s < DIV_STAGES; s++) begin
         cur[s]    = {rem_ff[s-1], 1'b0};
         src_q[s]  = q_ff[s-1];
         den_in[s] = den_ff[s-1];
         neg_in[s] = neg_ff[s-1];
      end
   end

   // compare and subtract
   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (cur[s] >= {1'b0, den_in[s]}) begin
            rem_in[s] = 33'(cur[s] - {1'b0, den_in[s]});
            q_in[s]   = {src_q[s][29:0], 1'b1};
         end else begin
            rem_in[s] = cur[s][32:0];
            q_in[s]   = {src_q[s][29:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
         den_ff <= den_in;
         neg_ff <= neg_in;
      end
   end

   // apply the sign, truncation toward zero
   assign quot = neg_ff[DIV_STAGES-1] ? 32'(33'd0 - {2'b00, q_ff[DIV_STAGES-1]})
                                      : {1'b0, q_ff[DIV_STAGES-1]};

endmodule

// ===== design/m2q_select.sv =====
// merge stage: trace test, diagonal pick, root argument and numerators
module m2q_select import m2q_pkg::*; (
   input  logic            clock,
   input  logic            enable,
   input  logic [8:0][31:0] n,
   input  logic            degen,
   output sel_type         sel
);

   logic signed [33:0] d [9];
   logic signed [33:0] tr;
   logic               pos;
   logic               pick1;
   logic               pick2;
   logic signed [33:0] dmax01;
   logic [1:0]         idx;
   logic signed [33:0] nii;
   logic signed [33:0] njj;
   logic signed [33:0] nkk;
   logic signed [33:0] t_el;
   logic signed [33:0] t;
   logic signed [33:0] num [4];
   logic [3:0]         half_sel;
   sel_type            sel_in;
   sel_type            sel_ff;

   // sign extend the normalized entries
   always_comb begin
      for (int e = 0; e < 9; e++) begin
         d[e] = 34'($signed(n[e]));
      end
   end

   // trace and largest diagonal, ties keep the lower index
   always_comb begin
      tr     = d[0] + d[4] + d[8];
      pos    = tr > 34'sd0;
      pick1  = d[4] > d[0];
      dmax01 = pick1 ? d[4] : d[0];
      pick2  = d[8] > dmax01;
      idx    = pick2 ? IDX_2 : (pick1 ? IDX_1 : IDX_0);
   end

   // numerators per component, cyclic next index
   always_comb begin
      case (idx)
         IDX_1: begin
            nii = d[4]; njj = d[8]; nkk = d[0];
            num[0] = d[2] - d[6];
            num[1] = d[1] + d[3];
            num[2] = '0;
            num[3] = d[7] + d[5];
            half_sel = HALF_Y;
         end
         IDX_2: begin
            nii = d[8]; njj = d[0]; nkk = d[4];
            num[0] = d[3] - d[1];
            num[1] = d[2] + d[6];
            num[2] = d[5] + d[7];
            num[3] = '0;
            half_sel = HALF_Z;
         end
         default: begin
            nii = d[0]; njj = d[4]; nkk = d[8];
            num[0] = d[7] - d[5];
            num[1] = '0;
            num[2] = d[3] + d[1];
            num[3] = d[6] + d[2];
            half_sel = HALF_X;
         end
      endcase
      if (pos) begin
         num[0] = '0;
         num[1] = d[7] - d[5];
         num[2] = d[2] - d[6];
         num[3] = d[3] - d[1];
         half_sel = HALF_W;
      end
   end

   // root argument, clamped to one on the diagonal path
   always_comb begin
      t_el = ONE_Q + nii - njj - nkk;
      if (t_el < ONE_Q) begin
         t_el = ONE_Q;
      end
      t = pos ? ONE_Q + tr : t_el;
   end

   always_comb begin
      sel_in.degen    = degen;
      sel_in.half_sel = half_sel;
      sel_in.arg      = 64'(unsigned'(t)) << Q_BITS;
      for (int c = 0; c < 4; c++) begin
         sel_in.num_neg[c] = num[c][33];
         sel_in.num_mag[c] = num[c][33] ? 32'(34'sd0 - num[c]) : num[c][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sel_ff <= sel_in;
      end
   end

   assign sel = sel_ff;

endmodule

// ===== design/matrix_to_quaternion_top.sv =====
// rotation and scale matrix to quaternion converter, top level
// throughput: one item per cycle; the pipeline advances whenever the output register is free
// the depth is set by two 32-stage square root steps (length roots, final root) and two 31-stage divider banks
// reset (synchronous, active high) clears all valid bits; payload registers are not reset
module matrix_to_quaternion_top import m2q_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic                  adv;
   logic [8:0][31:0]      m_a_in;
   logic [8:0][31:0]      mag_a_in;
   logic [8:0][63:0]      sq_a_in;
   logic [8:0][31:0]      m_a_ff;
   logic [8:0][63:0]      sq_a_ff;
   logic                  va_ff;
   logic [2:0][63:0]      col_b_ff;
   logic [8:0][31:0]      m_b_ff;
   logic                  vb_ff;
   logic [8:0][31:0]      m_d_ff [SQRT_STAGES];
   logic [SQRT_STAGES-1:0] vd_ff;
   logic [2:0][31:0]      len;
   logic                  degen_c;
   logic [8:0][31:0]      mag_c;
   logic [8:0]            neg_c;
   logic [8:0][31:0]      n;
   logic [DIV_STAGES-1:0] dg_ff;
   logic [DIV_STAGES-1:0] vn_ff;
   sel_type               sel;
   logic                  ve_ff;
   logic [31:0]           root2;
   sel_type               sd_ff [SQRT_STAGES];
   logic [SQRT_STAGES-1:0] vs_ff;
   logic [3:0][31:0]      q2;
   fin_type               fin_in;
   fin_type               fin_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0] vf_ff;
   logic [3:0][31:0]      comp;
   rsp_type               rsp_in;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;

   // narrow Q.30 to the output format, half away from zero, saturate
   function automatic logic [31:0] to_out(input logic [31:0] v);
      logic [32:0] vs;
      logic [32:0] mag;
      logic [32:0] rnd;
      logic [31:0] r;
      vs  = {v[31], v};
      mag = v[31] ? 33'(33'd0 - vs) : vs;
      rnd = 33'(mag + 33'(ROUND_HALF)) >> OUT_SHIFT;
      if (v[31]) begin
         r = (rnd > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(33'd0 - rnd);
      end else begin
         r = (rnd > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : rnd[31:0];
      end
      return r;
   endfunction

   // whole pipeline moves when the output register can take a result
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // squares of the entry magnitudes
   always_comb begin
      m_a_in = {req_data.r2c2, req_data.r2c1, req_data.r2c0,
                req_data.r1c2, req_data.r1c1, req_data.r1c0,
                req_data.r0c2, req_data.r0c1, req_data.r0c0};
      for (int e = 0; e < 9; e++) begin
         mag_a_in[e] = m_a_in[e][31] ? 32'(32'd0 - m_a_in[e]) : m_a_in[e];
         sq_a_in[e]  = 64'(mag_a_in[e]) * 64'(mag_a_in[e]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_a_ff  <= m_a_in;
         sq_a_ff <= sq_a_in;
         m_b_ff  <= m_a_ff;
         for (int c = 0; c < 3; c++) begin
            col_b_ff[c] <= sq_a_ff[c] + sq_a_ff[3+c] + sq_a_ff[6+c];
         end
      end
   end

   // column length lanes
   for (genvar c = 0; c < 3; c++) begin : g_len
      m2q_sqrt u_len (
         .clock    (clock),
         .enable   (adv),
         .radicand (col_b_ff[c]),
         .root     (len[c])
      );
   end

   // matrix rides alongside the length roots
   always_ff @(posedge clock) begin
      if (adv) begin
         m_d_ff[0] <= m_b_ff;
         for (int s = 1; s < SQRT_STAGES; s++) begin
            m_d_ff[s] <= m_d_ff[s-1];
         end
      end
   end

   // normalize: one divider lane per entry
   always_comb begin
      degen_c = (len[0] == '0) || (len[1] == '0) || (len[2] == '0);
      for (int e = 0; e < 9; e++) begin
         neg_c[e] = m_d_ff[SQRT_STAGES-1][e][31];
         mag_c[e] = neg_c[e] ? 32'(32'd0 - m_d_ff[SQRT_STAGES-1][e])
                             : m_d_ff[SQRT_STAGES-1][e];
      end
   end

   for (genvar e = 0; e < 9; e++) begin : g_norm
      m2q_div u_norm (
         .clock   (clock),
         .enable  (adv),
         .num_mag (mag_c[e]),
         .num_neg (neg_c[e]),
         .den     ({1'b0, len[e % 3]}),
         .quot    (n[e])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dg_ff <= {dg_ff[DIV_STAGES-2:0], degen_c};
      end
   end

   // merge the lanes
   m2q_select u_select (
      .clock  (clock),
      .enable (adv),
      .n      (n),
      .degen  (dg_ff[DIV_STAGES-1]),
      .sel    (sel)
   );

   m2q_sqrt u_root (
      .clock    (clock),
      .enable   (adv),
      .radicand (sel.arg),
      .root     (root2)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         sd_ff[0] <= sel;
         for (int s = 1; s < SQRT_STAGES; s++) begin
            sd_ff[s] <= sd_ff[s-1];
         end
      end
   end

   // component divides by twice the root
   for (genvar c = 0; c < 4; c++) begin : g_comp
      m2q_div u_comp (
         .clock   (clock),
         .enable  (adv),
         .num_mag (sd_ff[SQRT_STAGES-1].num_mag[c]),
         .num_neg (sd_ff[SQRT_STAGES-1].num_neg[c]),
         .den     ({root2, 1'b0}),
         .quot    (q2[c])
      );
   end

   always_comb begin
      fin_in.degen    = sd_ff[SQRT_STAGES-1].degen;
      fin_in.half_sel = sd_ff[SQRT_STAGES-1].half_sel;
      fin_in.half_val = root2[31:1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_ff[0] <= fin_in;
         for (int s = 1; s < DIV_STAGES; s++) begin
            fin_ff[s] <= fin_ff[s-1];
         end
      end
   end

   // output formatting
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         if (fin_ff[DIV_STAGES-1].degen) begin
            comp[c] = '0;
         end else if (fin_ff[DIV_STAGES-1].half_sel[c]) begin
            comp[c] = {1'b0, fin_ff[DIV_STAGES-1].half_val};
         end else begin
            comp[c] = q2[c];
         end
      end
      rsp_in.quat_w     = to_out(comp[0]);
      rsp_in.quat_x     = to_out(comp[1]);
      rsp_in.quat_y     = to_out(comp[2]);
      rsp_in.quat_z     = to_out(comp[3]);
      rsp_in.degenerate = fin_ff[DIV_STAGES-1].degen;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // valid bits along the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vd_ff        <= '0;
         vn_ff        <= '0;
         ve_ff        <= 1'b0;
         vs_ff        <= '0;
         vf_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         va_ff        <= req_valid;
         vb_ff        <= va_ff;
         vd_ff        <= {vd_ff[SQRT_STAGES-2:0], vb_ff};
         vn_ff        <= {vn_ff[DIV_STAGES-2:0], vd_ff[SQRT_STAGES-1]};
         ve_ff        <= vn_ff[DIV_STAGES-1];
         vs_ff        <= {vs_ff[SQRT_STAGES-2:0], ve_ff};
         vf_ff        <= {vf_ff[DIV_STAGES-2:0], vs_ff[SQRT_STAGES-1]};
         rsp_valid_ff <= vf_ff[DIV_STAGES-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // degenerate items carry a zero quaternion
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.quat_w == '0 && rsp_data.quat_x == '0 &&
         rsp_data.quat_y == '0 && rsp_data.quat_z == '0)
      else $error("degenerate item with nonzero quaternion");

   // a normal item never has an all-zero quaternion
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.degenerate |->
         (rsp_data.quat_w | rsp_data.quat_x | rsp_data.quat_y | rsp_data.quat_z) != '0)
      else $error("normal item with zero quaternion");

   // a stalled pipeline holds its first stage
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(va_ff))
      else $error("pipeline moved while stalled");

   // no result straight out of reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
